[sv/binary_heap_priority_queue_assert.svh]
// assertion macros for the binary heap priority queue
// each macro expects signals named clk and rst_n in the calling scope
`ifndef BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH
`define BINARY_HEAP_PRIORITY_QUEUE_ASSERT_SVH

// same-cycle implication, checked at every rising edge outside reset
`define BHPQ_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BHPQ_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/bhpq_pkg.sv]
// ----------------------------------------------------------------------------
// bhpq_pkg
// shared constants, status codes and the key compare for the heap queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bhpq_pkg;

  localparam int KEY_W        = 32;
  localparam int CAPACITY_DEF = 64;
  localparam int TAG_BITS_DEF = 16;

  typedef logic [1:0] status_t;

  localparam status_t STAT_OK    = 2'd0;
  localparam status_t STAT_EMPTY = 2'd1;
  localparam status_t STAT_FULL  = 2'd2;

  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_POP    = 1'b1;

  localparam logic ORDER_MAX = 1'b0;
  localparam logic ORDER_MIN = 1'b1;

  // true when key a should sit above key b
  function automatic logic key_better(input logic ord,
                                      input logic signed [KEY_W-1:0] a,
                                      input logic signed [KEY_W-1:0] b);
    logic res;
    if (ord == ORDER_MIN) begin
      res = (a < b);
    end else begin
      res = (a > b);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

[sv/bhpq_ram.sv]
// ----------------------------------------------------------------------------
// bhpq_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bhpq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

[sv/bhpq_engine.sv]
// ----------------------------------------------------------------------------
// bhpq_engine
// sequencer for insert with sift-up and pop with sift-down over the heap ram
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bhpq_engine
  import bhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int EW = KEY_W + TAG_BITS
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  // operation beat
  input  wire logic                op_valid,
  output logic                     op_ready,
  input  wire logic                op_code,
  input  wire logic [KEY_W-1:0]    op_key,
  input  wire logic [TAG_BITS-1:0] op_tag,
  // order register write
  input  wire logic                cfg_wr,
  input  wire logic                cfg_order,
  // heap ram
  output logic                     mem_we,
  output logic [AW-1:0]            mem_waddr,
  output logic [EW-1:0]            mem_wdata,
  output logic                     mem_re,
  output logic [AW-1:0]            mem_raddr,
  input  wire logic [EW-1:0]       mem_rdata,
  // result
  output logic                     res_valid,
  input  wire logic                res_ready,
  output logic [KEY_W-1:0]         res_key,
  output logic [TAG_BITS-1:0]      res_tag,
  output status_t                  res_status,
  output logic [CW-1:0]            res_count
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_UP_RD    = 4'd1;
  localparam logic [3:0] S_UP_CMP   = 4'd2;
  localparam logic [3:0] S_POP_LAST = 4'd3;
  localparam logic [3:0] S_POP_WAIT = 4'd4;
  localparam logic [3:0] S_DN_RD_L  = 4'd5;
  localparam logic [3:0] S_DN_RD_R  = 4'd6;
  localparam logic [3:0] S_DN_CMP   = 4'd7;
  localparam logic [3:0] S_OUT      = 4'd8;

  logic [3:0]          state_r, state_nxt;
  logic [CW-1:0]       count_r, count_nxt;
  logic                order_r, order_nxt;
  logic [CW-1:0]       idx_r, idx_nxt;
  logic [EW-1:0]       ent_r, ent_nxt;
  logic [EW-1:0]       lft_r, lft_nxt;
  logic [KEY_W-1:0]    res_key_r, res_key_nxt;
  logic [TAG_BITS-1:0] res_tag_r, res_tag_nxt;
  status_t             res_status_r, res_status_nxt;

  logic [CW-1:0] parent_idx;
  logic [CW:0]   lft_idx;
  logic [CW:0]   rgt_idx;
  logic          lft_ok;
  logic          rgt_ok;
  logic          pick_rgt;
  logic [CW:0]   child_idx;
  logic [EW-1:0] child_ent;

  assign parent_idx = CW'((idx_r - CW'(1)) >> 1);
  assign lft_idx    = {idx_r, 1'b1};
  assign rgt_idx    = lft_idx + (CW + 1)'(1);
  assign lft_ok     = lft_idx < {1'b0, count_r};
  assign rgt_ok     = rgt_idx < {1'b0, count_r};

  // in the compare state the right child has just come out of the ram
  assign pick_rgt  = rgt_ok && key_better(order_r, $signed(mem_rdata[KEY_W-1:0]),
                                          $signed(lft_r[KEY_W-1:0]));
  assign child_idx = pick_rgt ? rgt_idx : lft_idx;
  assign child_ent = pick_rgt ? mem_rdata : lft_r;

  assign op_ready   = (state_r == S_IDLE);
  assign res_valid  = (state_r == S_OUT);
  assign res_key    = res_key_r;
  assign res_tag    = res_tag_r;
  assign res_status = res_status_r;
  assign res_count  = count_r;

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    order_nxt      = order_r;
    idx_nxt        = idx_r;
    ent_nxt        = ent_r;
    lft_nxt        = lft_r;
    res_key_nxt    = res_key_r;
    res_tag_nxt    = res_tag_r;
    res_status_nxt = res_status_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = ent_r;
    mem_re         = 1'b0;
    mem_raddr      = '0;

    // order only changes on an empty heap
    if (cfg_wr && count_r == '0) begin
      order_nxt = cfg_order;
    end

    unique case (state_r)
      S_IDLE: begin
        if (op_valid) begin
          res_key_nxt    = '0;
          res_tag_nxt    = '0;
          res_status_nxt = STAT_OK;
          if (op_code == OP_INSERT) begin
            if (count_r == CW'(CAPACITY)) begin
              res_status_nxt = STAT_FULL;
              state_nxt      = S_OUT;
            end else begin
              ent_nxt   = {op_tag, op_key};
              idx_nxt   = count_r;
              count_nxt = count_r + CW'(1);
              state_nxt = S_UP_RD;
            end
          end else begin
            if (count_r == '0) begin
              res_status_nxt = STAT_EMPTY;
              state_nxt      = S_OUT;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              count_nxt = count_r - CW'(1);
              state_nxt = S_POP_LAST;
            end
          end
        end
      end
      S_UP_RD: begin
        if (idx_r == '0) begin
          mem_we    = 1'b1;
          state_nxt = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = parent_idx[AW-1:0];
          state_nxt = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        mem_we = 1'b1;
        if (key_better(order_r, $signed(ent_r[KEY_W-1:0]),
                       $signed(mem_rdata[KEY_W-1:0]))) begin
          // parent moves down into the hole
          mem_wdata = mem_rdata;
          idx_nxt   = parent_idx;
          state_nxt = S_UP_RD;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_POP_LAST: begin
        res_key_nxt = mem_rdata[KEY_W-1:0];
        res_tag_nxt = mem_rdata[KEY_W +: TAG_BITS];
        if (count_r == '0) begin
          state_nxt = S_OUT;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = count_r[AW-1:0];
          state_nxt = S_POP_WAIT;
        end
      end
      S_POP_WAIT: begin
        ent_nxt   = mem_rdata;
        idx_nxt   = '0;
        state_nxt = S_DN_RD_L;
      end
      S_DN_RD_L: begin
        if (lft_ok) begin
          mem_re    = 1'b1;
          mem_raddr = lft_idx[AW-1:0];
          state_nxt = S_DN_RD_R;
        end else begin
          mem_we    = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_DN_RD_R: begin
        lft_nxt = mem_rdata;
        if (rgt_ok) begin
          mem_re    = 1'b1;
          mem_raddr = rgt_idx[AW-1:0];
        end
        state_nxt = S_DN_CMP;
      end
      S_DN_CMP: begin
        mem_we = 1'b1;
        if (key_better(order_r, $signed(child_ent[KEY_W-1:0]),
                       $signed(ent_r[KEY_W-1:0]))) begin
          // child moves up into the hole
          mem_wdata = child_ent;
          idx_nxt   = child_idx[CW-1:0];
          state_nxt = S_DN_RD_L;
        end else begin
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      order_r <= ORDER_MAX;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      order_r <= order_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    ent_r        <= ent_nxt;
    lft_r        <= lft_nxt;
    res_key_r    <= res_key_nxt;
    res_tag_r    <= res_tag_nxt;
    res_status_r <= res_status_nxt;
  end

endmodule

`default_nettype wire

[sv/binary_heap_priority_queue.sv]
// ----------------------------------------------------------------------------
// binary_heap_priority_queue
// bounded binary heap of key/tag entries served largest or smallest key first
//   in_*  one beat per operation: in_tuser insert (0) or pop (1), in_tdata
//         the signed key and the tag of an insert
//   out_* one result beat per operation, in order: popped key and tag (zero
//         for inserts and errors), status on out_tuser, fill count after it
//   cfg_* order bit (0 max first, 1 min first), always accepted, takes
//         effect only while the heap is empty
// One ram, registered read. Errors go straight to the result. An insert
//   opens a hole at the end and climbs: read the parent, compare, move the
//   parent down into the hole, until the root or a compare stops it, then
//   writes the entry into the hole. A pop reads the root, then, unless the
//   heap is now empty, the last entry, and sinks it: read the left child,
//   the right one if present, compare, move the better child up, until a
//   leaf or a compare stops it. The next beat is taken only after the
//   result has been parked in the output register.
// Reset empties the heap and selects max order. A stalled receiver holds
//   the result beat; the engine waits once a second result is ready.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module binary_heap_priority_queue
  import bhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  localparam int AW  = $clog2(CAPACITY),
  localparam int CW  = $clog2(CAPACITY + 1),
  localparam int EW  = KEY_W + TAG_BITS,
  localparam int IDW = ((KEY_W + TAG_BITS + 7) / 8) * 8,
  localparam int ODW = ((KEY_W + TAG_BITS + CW + 7) / 8) * 8
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  input  wire logic [IDW-1:0] in_tdata,   // item_key, item_tag, zero pad
  input  wire logic           in_tuser,   // operation
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output logic      [ODW-1:0] out_tdata,  // out_key, out_tag, fill_count, zero pad
  output logic      [1:0]     out_tuser,  // status
  input  wire logic           cfg_valid,
  output logic                cfg_ready,
  input  wire logic           cfg_data
);

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [EW-1:0]       mem_wdata;
  logic                mem_re;
  logic [AW-1:0]       mem_raddr;
  logic [EW-1:0]       mem_rdata;

  logic                res_valid;
  logic                res_ready;
  logic [KEY_W-1:0]    res_key;
  logic [TAG_BITS-1:0] res_tag;
  status_t             res_status;
  logic [CW-1:0]       res_count;

  logic                out_valid_r;
  logic [ODW-1:0]      out_data_r;
  status_t             out_status_r;

  assign cfg_ready = 1'b1;

  bhpq_ram #(
    .WIDTH(EW),
    .DEPTH(CAPACITY)
  ) u_ram (
    .clk    (clk),
    .wr_en  (mem_we),
    .wr_addr(mem_waddr),
    .wr_data(mem_wdata),
    .rd_en  (mem_re),
    .rd_addr(mem_raddr),
    .rd_data(mem_rdata)
  );

  bhpq_engine #(
    .CAPACITY(CAPACITY),
    .TAG_BITS(TAG_BITS)
  ) u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (in_tvalid),
    .op_ready  (in_tready),
    .op_code   (in_tuser),
    .op_key    (in_tdata[KEY_W-1:0]),
    .op_tag    (in_tdata[KEY_W +: TAG_BITS]),
    .cfg_wr    (cfg_valid && cfg_ready),
    .cfg_order (cfg_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_key   (res_key),
    .res_tag   (res_tag),
    .res_status(res_status),
    .res_count (res_count)
  );

  // output register parts the engine from the receiver
  assign res_ready = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_ready) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_data_r   <= ODW'({res_count, res_tag, res_key});
      out_status_r <= res_status;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_status_r;

endmodule

`default_nettype wire

[sv/bhpq_checker.sv]
// ----------------------------------------------------------------------------
// bhpq_checker
// port-level checks on result beats of the heap queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "binary_heap_priority_queue_assert.svh"

module bhpq_checker
  import bhpq_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF,
  parameter int TAG_BITS = TAG_BITS_DEF,
  localparam int CW  = $clog2(CAPACITY + 1),
  localparam int IDW = ((KEY_W + TAG_BITS + 7) / 8) * 8,
  localparam int ODW = ((KEY_W + TAG_BITS + CW + 7) / 8) * 8
) (
  input wire logic           clk,
  input wire logic           rst_n,
  input wire logic           in_tvalid,
  input wire logic           in_tready,
  input wire logic [IDW-1:0] in_tdata,
  input wire logic           in_tuser,
  input wire logic           out_tvalid,
  input wire logic           out_tready,
  input wire logic [ODW-1:0] out_tdata,
  input wire logic [1:0]     out_tuser,
  input wire logic           cfg_valid,
  input wire logic           cfg_ready,
  input wire logic           cfg_data
);

  logic [KEY_W-1:0]    chk_key;
  logic [TAG_BITS-1:0] chk_tag;
  logic [CW-1:0]       chk_count;
  logic                chk_unused;

  assign chk_key    = out_tdata[KEY_W-1:0];
  assign chk_tag    = out_tdata[KEY_W +: TAG_BITS];
  assign chk_count  = out_tdata[KEY_W + TAG_BITS +: CW];
  assign chk_unused = ^{in_tvalid, in_tready, in_tdata, in_tuser, cfg_valid, cfg_ready,
                        cfg_data};

  `BHPQ_ASSERT_NOW(a_count_bound, out_tvalid, chk_count <= CW'(CAPACITY), "fill count above capacity")

  `BHPQ_ASSERT_NOW(a_error_zero, out_tvalid && out_tuser != STAT_OK, chk_key == '0 && chk_tag == '0 && !$isunknown(chk_unused) || chk_key == '0 && chk_tag == '0, "error beat carries data")

  `BHPQ_ASSERT_NOW(a_empty_count, out_tvalid && out_tuser == STAT_EMPTY, chk_count == '0, "empty status with entries held")

  `BHPQ_ASSERT_NOW(a_full_count, out_tvalid && out_tuser == STAT_FULL, chk_count == CW'(CAPACITY), "full status below capacity")

  `BHPQ_ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser), "stalled result beat changed")

endmodule

bind binary_heap_priority_queue bhpq_checker #(
  .CAPACITY(CAPACITY),
  .TAG_BITS(TAG_BITS)
) u_bhpq_checker (.*);

`default_nettype wire

[tb/sv/tb.sv]
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the binary heap priority queue: a behavioral heap
// predicts every result beat, which is compared field by field on arrival
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tb;
  import bhpq_pkg::*;

  localparam int HEAP_CAP   = CAPACITY_DEF;
  localparam int SETTLE_CYC = 40;
  localparam int CYCLE_CAP  = 400000;

  typedef struct {
    logic signed [KEY_W-1:0] key;
    logic [15:0]             tag;
    status_t                 status;
    logic [6:0]              fill;
  } heap_result_t;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [47:0] in_tdata;   // item_key, item_tag
  logic        in_tuser;   // operation
  logic        out_tvalid;
  logic        out_tready;
  logic [55:0] out_tdata;  // out_key, out_tag, fill_count, zero pad
  logic [1:0]  out_tuser;  // status
  logic        cfg_valid;
  logic        cfg_ready;
  logic        cfg_data;

  // behavioral heap
  logic signed [KEY_W-1:0] heap_keys [HEAP_CAP];
  logic [15:0]             heap_tags [HEAP_CAP];
  int                      heap_fill;
  logic                    heap_order;

  heap_result_t owed_results[$];
  bit           mismatch_seen;
  bit           no_idle;
  int           stall_left;
  int           cycle_count;

  binary_heap_priority_queue u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic bit outranks(input logic signed [KEY_W-1:0] a,
                                  input logic signed [KEY_W-1:0] b);
    if (heap_order == ORDER_MIN) begin
      return a < b;
    end
    return a > b;
  endfunction

  function automatic void swap_slots(input int i, input int j);
    logic signed [KEY_W-1:0] k;
    logic [15:0]             t;
    k = heap_keys[i];
    t = heap_tags[i];
    heap_keys[i] = heap_keys[j];
    heap_tags[i] = heap_tags[j];
    heap_keys[j] = k;
    heap_tags[j] = t;
  endfunction

  function automatic heap_result_t predict_heap_op(input logic op,
                                                   input logic signed [KEY_W-1:0] key,
                                                   input logic [15:0] tag);
    heap_result_t r;
    int           i;
    int           p;
    int           c;
    r.key    = '0;
    r.tag    = '0;
    r.status = STAT_OK;
    if (op == OP_INSERT) begin
      if (heap_fill >= HEAP_CAP) begin
        r.status = STAT_FULL;
      end else begin
        heap_keys[heap_fill] = key;
        heap_tags[heap_fill] = tag;
        i = heap_fill;
        heap_fill++;
        while (i > 0) begin
          p = (i - 1) / 2;
          if (!outranks(heap_keys[i], heap_keys[p])) break;
          swap_slots(i, p);
          i = p;
        end
      end
    end else begin
      if (heap_fill == 0) begin
        r.status = STAT_EMPTY;
      end else begin
        r.key = heap_keys[0];
        r.tag = heap_tags[0];
        heap_fill--;
        if (heap_fill > 0) begin
          heap_keys[0] = heap_keys[heap_fill];
          heap_tags[0] = heap_tags[heap_fill];
          i = 0;
          while (2 * i + 1 < heap_fill) begin
            c = 2 * i + 1;
            // right child wins only when strictly better
            if (c + 1 < heap_fill && outranks(heap_keys[c + 1], heap_keys[c])) c = c + 1;
            if (!outranks(heap_keys[c], heap_keys[i])) break;
            swap_slots(i, c);
            i = c;
          end
        end
      end
    end
    r.fill = heap_fill[6:0];
    return r;
  endfunction

  // predict on accepted input beats, check accepted result beats
  always @(posedge clk) begin : beat_monitor
    heap_result_t exp_r;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (owed_results.size() == 0) begin
          $display("%0t: result beat with nothing owed: key %0d tag %0h status %0d fill %0d",
                   $time, $signed(out_tdata[31:0]), out_tdata[47:32], out_tuser,
                   out_tdata[54:48]);
          mismatch_seen = 1'b1;
        end else begin
          exp_r = owed_results.pop_front();
          if (out_tdata[31:0] !== exp_r.key) begin
            $display("%0t: key expected %0d actual %0d", $time, exp_r.key,
                     $signed(out_tdata[31:0]));
            mismatch_seen = 1'b1;
          end
          if (out_tdata[47:32] !== exp_r.tag) begin
            $display("%0t: tag expected %0h actual %0h", $time, exp_r.tag, out_tdata[47:32]);
            mismatch_seen = 1'b1;
          end
          if (out_tuser !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_tuser);
            mismatch_seen = 1'b1;
          end
          if (out_tdata[54:48] !== exp_r.fill) begin
            $display("%0t: fill expected %0d actual %0d", $time, exp_r.fill,
                     out_tdata[54:48]);
            mismatch_seen = 1'b1;
          end
        end
      end
      if (in_tvalid && in_tready) begin
        owed_results.push_back(predict_heap_op(in_tuser, in_tdata[31:0], in_tdata[47:32]));
      end
      // order only changes on an empty heap
      if (cfg_valid && cfg_ready && heap_fill == 0) heap_order = cfg_data;
    end
  end

  // receiver back-pressure in bursts
  always @(posedge clk) begin
    if (!rst_n || no_idle) begin
      stall_left = 0;
      out_tready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 9) - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  task automatic send_op(input logic op, input logic signed [KEY_W-1:0] key,
                         input logic [15:0] tag);
    int gap;
    gap = 0;
    if (!no_idle && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 9);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {tag, key};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic insert(input logic signed [KEY_W-1:0] key, input logic [15:0] tag);
    send_op(OP_INSERT, key, tag);
  endtask

  task automatic pop();
    // key and tag are don't-care on a pop, so they carry noise
    send_op(OP_POP, $urandom, 16'($urandom_range(0, 65535)));
  endtask

  // stop sending and let every owed beat drain
  task automatic settle();
    in_tvalid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_order(input logic ord);
    cfg_valid <= 1'b1;
    cfg_data  <= ord;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic signed [KEY_W-1:0] random_key();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 7) - 4;     // crowded keys force ties
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      2: return $urandom_range(0, 200) - 100;
      default: return $urandom;
    endcase
  endfunction

  task automatic test_empty_pop();
    pop();
  endtask

  task automatic test_key_extremes();
    insert(32'sh7fffffff, 16'hffff);
    insert(32'sh80000000, 16'h0000);
    insert(32'sh00000000, 16'h1234);
    insert(-32'sd1, 16'ha5a5);
    insert(32'sd1, 16'h5a5a);
    pop();
    pop();
  endtask

  task automatic test_equal_keys();
    insert(32'sd100, 16'h0001);
    insert(32'sd100, 16'h0002);
    insert(32'sd100, 16'h0003);
  endtask

  // order write with entries held must be ignored
  task automatic test_order_locked();
    settle();
    write_order(ORDER_MIN);
    repeat (7) pop();
    settle();
  endtask

  task automatic test_min_order();
    write_order(ORDER_MIN);
    insert(32'sd5, 16'h0010);
    insert(-32'sd5, 16'h0020);
    insert(32'sd5, 16'h0030);
    repeat (4) pop();
  endtask

  task automatic test_fill_drain();
    int room;
    settle();
    room = HEAP_CAP - heap_fill;
    repeat (room + 3) insert(random_key(), 16'($urandom_range(0, 65535)));
    repeat (HEAP_CAP + 2) pop();
  endtask

  task automatic test_mixed_traffic(input int n, input int pop_pct);
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(1, 100) <= pop_pct) begin
        pop();
      end else begin
        insert(random_key(), 16'($urandom_range(0, 65535)));
      end
    end
  endtask

  task automatic drain_heap();
    settle();
    repeat (heap_fill + 1) pop();
    settle();
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_tvalid   <= 1'b0;
    in_tuser    <= OP_INSERT;
    in_tdata    <= '0;
    out_tready  <= 1'b1;
    cfg_valid   <= 1'b0;
    cfg_data    <= ORDER_MAX;
    heap_fill   = 0;
    heap_order  = ORDER_MAX;
    no_idle     = 1'b0;
    cycle_count = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    write_order(ORDER_MAX);
    test_empty_pop();
    test_key_extremes();
    test_equal_keys();
    test_order_locked();
    test_min_order();

    test_fill_drain();
    test_mixed_traffic(90, 30);
    test_mixed_traffic(90, 60);
    drain_heap();

    write_order(ORDER_MAX);
    test_fill_drain();
    drain_heap();

    no_idle = 1'b1;
    test_mixed_traffic(90, 35);
    test_mixed_traffic(90, 55);
    settle();

    if (!mismatch_seen) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire

[binary_heap_priority_queue.f]
+incdir+sv
sv/bhpq_pkg.sv
sv/bhpq_ram.sv
sv/bhpq_engine.sv
sv/binary_heap_priority_queue.sv
sv/bhpq_checker.sv
tb/sv/tb.sv
